### hdl/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg
// Shared constants, codes and types of the UART transmit/receive ring buffers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urb_pkg;

  // Ring depths, both powers of two
  localparam int unsigned SEND_DEPTH    = 256;
  localparam int unsigned RECEIVE_DEPTH = 256;
  localparam int unsigned MAX_READ_ROOM = 64;

  localparam int unsigned SEND_IDX_W    = $clog2(SEND_DEPTH);
  localparam int unsigned SEND_PTR_W    = SEND_IDX_W + 1;
  localparam int unsigned RECEIVE_IDX_W = $clog2(RECEIVE_DEPTH);
  localparam int unsigned RECEIVE_PTR_W = RECEIVE_IDX_W + 1;

  // Free-slot compare is done at the wider of pointer and length widths
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned SEND_CMP_W = (SEND_PTR_W > LEN_W) ? SEND_PTR_W : LEN_W;

  localparam int unsigned ROOM_W  = 7;
  localparam int unsigned COUNT_W = 6;

  localparam logic [7:0] TERM_RESET = 8'h0A;

  // Opcodes
  localparam logic [1:0] OP_SEND_BYTE = 2'd0;
  localparam logic [1:0] OP_TX_READY  = 2'd1;
  localparam logic [1:0] OP_RX_BYTE   = 2'd2;
  localparam logic [1:0] OP_LINE_READ = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_OUTCOME    = 3'd0;
  localparam logic [2:0] KIND_TX_BYTE    = 3'd1;
  localparam logic [2:0] KIND_DISARMED   = 3'd2;
  localparam logic [2:0] KIND_LINE_BYTE  = 3'd3;
  localparam logic [2:0] KIND_EMPTY_LINE = 3'd4;

  // Configuration register index (taken from the word address)
  localparam logic REG_LINE_TERM = 1'b0;

  typedef logic [SEND_PTR_W-1:0]    tx_ptr_t;
  typedef logic [RECEIVE_PTR_W-1:0] rx_ptr_t;
  typedef logic [SEND_CMP_W-1:0]    tx_cmp_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         data;
    logic               first;
    logic [LEN_W-1:0]   len;
    logic [COUNT_W-1:0] limit;    // saturated room minus one
    logic               no_room;  // room of 0 or 1
  } cmd_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         data;
    logic               accepted;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

endpackage

### hdl/urb_front.sv
// ----------------------------------------------------------------------------
// urb_front
// Accepts requests, saturates the read room and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urb_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [1:0]                       opcode_i,
  input  logic [7:0]                       data_in_i,
  input  logic                             first_of_block_i,
  input  logic [urb_pkg::LEN_W-1:0]        block_length_i,
  input  logic [urb_pkg::ROOM_W-1:0]       read_room_i,
  output logic                             cmd_valid_o,
  output urb_pkg::cmd_t                    cmd_o,
  input  logic                             cmd_pop_i
);

  urb_pkg::cmd_t             slot_q [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                count_q;
  urb_pkg::cmd_t             cmd_new;
  logic [urb_pkg::ROOM_W-1:0] room_sat;
  logic                      do_push, do_pop;

  always_comb begin
    if (read_room_i > urb_pkg::ROOM_W'(urb_pkg::MAX_READ_ROOM)) begin
      room_sat = urb_pkg::ROOM_W'(urb_pkg::MAX_READ_ROOM);
    end else begin
      room_sat = read_room_i;
    end
    cmd_new.op      = opcode_i;
    cmd_new.data    = data_in_i;
    cmd_new.first   = first_of_block_i;
    cmd_new.len     = block_length_i;
    cmd_new.limit   = urb_pkg::COUNT_W'(room_sat - urb_pkg::ROOM_W'(1));
    cmd_new.no_room = (room_sat <= urb_pkg::ROOM_W'(1));
  end

  assign full_o      = (count_q == 2'd2);
  assign do_push     = push_i && !full_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hdl/urb_back.sv
// ----------------------------------------------------------------------------
// urb_back
// Carries out requests on the transmit and receive rings and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  urb_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  input  logic [7:0]                 line_term_i,
  output logic                       res_valid_o,
  output urb_pkg::result_t           res_o,
  input  logic                       res_pop_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEND = 2'd1;
  localparam logic [1:0] ST_LINE = 2'd2;

  logic [7:0] tx_mem [urb_pkg::SEND_DEPTH];
  logic [7:0] rx_mem [urb_pkg::RECEIVE_DEPTH];

  logic [1:0]                  state_q, state_d;
  urb_pkg::tx_ptr_t            tx_rptr_q, tx_rptr_d, tx_wptr_q, tx_wptr_d;
  urb_pkg::rx_ptr_t            rx_rptr_q, rx_rptr_d, rx_wptr_q, rx_wptr_d;
  logic                        armed_q, armed_d, admitted_q, admitted_d;
  logic [urb_pkg::LEN_W-1:0]   remain_q, remain_d;
  logic [urb_pkg::COUNT_W-1:0] n_q, n_d, limit_q, limit_d;
  logic [7:0]                  tx_rd_q, rx_rd_q;
  urb_pkg::result_t            out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  logic                        out_free, take, emit, stop;
  urb_pkg::result_t            res;
  logic                        tx_we, tx_re, rx_we, rx_re;
  urb_pkg::tx_ptr_t            tx_used, tx_free;
  urb_pkg::rx_ptr_t            rx_used;

  assign tx_used  = tx_wptr_q - tx_rptr_q;
  assign tx_free  = urb_pkg::tx_ptr_t'(urb_pkg::SEND_DEPTH) - tx_used;
  assign rx_used  = rx_wptr_q - rx_rptr_q;
  assign out_free = !out_valid_q || res_pop_i;
  assign take     = (state_q == ST_IDLE) && cmd_valid_i && out_free;
  assign cmd_pop_o = take;

  // stop test on the byte just read; pointer already moved past it
  assign stop = (rx_rd_q == line_term_i) || (rx_rptr_q == rx_wptr_q) || (n_q >= limit_q);

  always_comb begin
    state_d    = state_q;
    tx_rptr_d  = tx_rptr_q;
    tx_wptr_d  = tx_wptr_q;
    rx_rptr_d  = rx_rptr_q;
    rx_wptr_d  = rx_wptr_q;
    armed_d    = armed_q;
    admitted_d = admitted_q;
    remain_d   = remain_q;
    n_d        = n_q;
    limit_d    = limit_q;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    emit       = 1'b0;
    res        = '0;
    res.last   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (cmd_i.op)
            urb_pkg::OP_SEND_BYTE: begin
              emit     = 1'b1;
              res.kind = urb_pkg::KIND_OUTCOME;
              if (cmd_i.first) begin
                admitted_d = 1'b0;
                remain_d   = '0;
                if (cmd_i.len == '0) begin
                  armed_d      = 1'b1;
                  res.accepted = 1'b1;
                end else if (urb_pkg::tx_cmp_t'(tx_free) >= urb_pkg::tx_cmp_t'(cmd_i.len)) begin
                  tx_we        = 1'b1;
                  res.accepted = 1'b1;
                  remain_d     = cmd_i.len - urb_pkg::LEN_W'(1);
                  if (cmd_i.len == urb_pkg::LEN_W'(1)) begin
                    armed_d = 1'b1;
                  end else begin
                    admitted_d = 1'b1;
                  end
                end
              end else if (admitted_q) begin
                tx_we        = 1'b1;
                res.accepted = 1'b1;
                remain_d     = remain_q - urb_pkg::LEN_W'(1);
                if (remain_q == urb_pkg::LEN_W'(1)) begin
                  admitted_d = 1'b0;
                  armed_d    = 1'b1;
                end
              end
              if (tx_we) begin
                tx_wptr_d = tx_wptr_q + urb_pkg::tx_ptr_t'(1);
              end
            end
            urb_pkg::OP_TX_READY: begin
              if (armed_q) begin
                if (tx_used == '0) begin
                  armed_d  = 1'b0;
                  emit     = 1'b1;
                  res.kind = urb_pkg::KIND_DISARMED;
                end else begin
                  tx_re     = 1'b1;
                  tx_rptr_d = tx_rptr_q + urb_pkg::tx_ptr_t'(1);
                  state_d   = ST_SEND;
                end
              end
            end
            urb_pkg::OP_RX_BYTE: begin
              emit     = 1'b1;
              res.kind = urb_pkg::KIND_OUTCOME;
              if (rx_used != urb_pkg::rx_ptr_t'(urb_pkg::RECEIVE_DEPTH)) begin
                rx_we        = 1'b1;
                rx_wptr_d    = rx_wptr_q + urb_pkg::rx_ptr_t'(1);
                res.accepted = 1'b1;
              end
            end
            urb_pkg::OP_LINE_READ: begin
              if (cmd_i.no_room || (rx_used == '0)) begin
                emit     = 1'b1;
                res.kind = urb_pkg::KIND_EMPTY_LINE;
              end else begin
                rx_re     = 1'b1;
                rx_rptr_d = rx_rptr_q + urb_pkg::rx_ptr_t'(1);
                n_d       = urb_pkg::COUNT_W'(1);
                limit_d   = cmd_i.limit;
                state_d   = ST_LINE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEND: begin
        if (out_free) begin
          emit     = 1'b1;
          res.kind = urb_pkg::KIND_TX_BYTE;
          res.data = tx_rd_q;
          state_d  = ST_IDLE;
        end
      end
      ST_LINE: begin
        if (out_free) begin
          emit     = 1'b1;
          res.kind = urb_pkg::KIND_LINE_BYTE;
          res.data = rx_rd_q;
          res.last = stop;
          res.count = stop ? n_q : '0;
          if (stop) begin
            state_d = ST_IDLE;
          end else begin
            // fetch the next byte while this one goes out
            rx_re     = 1'b1;
            rx_rptr_d = rx_rptr_q + urb_pkg::rx_ptr_t'(1);
            n_d       = n_q + urb_pkg::COUNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_d       = out_q;
    out_valid_d = out_valid_q && !res_pop_i;
    if (emit) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_wptr_q[urb_pkg::SEND_IDX_W-1:0]] <= cmd_i.data;
    end
    if (tx_re) begin
      tx_rd_q <= tx_mem[tx_rptr_q[urb_pkg::SEND_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_wptr_q[urb_pkg::RECEIVE_IDX_W-1:0]] <= cmd_i.data;
    end
    if (rx_re) begin
      rx_rd_q <= rx_mem[rx_rptr_q[urb_pkg::RECEIVE_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    limit_q <= limit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tx_rptr_q   <= '0;
      tx_wptr_q   <= '0;
      rx_rptr_q   <= '0;
      rx_wptr_q   <= '0;
      armed_q     <= 1'b0;
      admitted_q  <= 1'b0;
      remain_q    <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tx_rptr_q   <= tx_rptr_d;
      tx_wptr_q   <= tx_wptr_d;
      rx_rptr_q   <= rx_rptr_d;
      rx_wptr_q   <= rx_wptr_d;
      armed_q     <= armed_d;
      admitted_q  <= admitted_d;
      remain_q    <= remain_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hdl/uart_tx_rx_ring_buffers.sv
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers
// Transmit and receive byte rings with block admission and line reads.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  request   in         push / full        opcode, data_in, first_of_block,
//                                          block_length, read_room
//  result    out        empty / pop        result_kind, data_out, accepted,
//                                          line_count, last
//  config    in         APB psel/penable   line_terminator at byte address 0
//
//  A taken request has its results registered into the output slot; a transmitter
//  byte first passes the registered ring read. A line read, after its ring read,
//  gives one byte per cycle while the output slot is free or being popped.
//  A two-entry request queue lets requests arrive while a result waits.
//  Reset empties both rings, disarms the transmitter and sets the terminator
//  to newline; ring contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 opcode_i,
  input  logic [7:0]                 data_in_i,
  input  logic                       first_of_block_i,
  input  logic [urb_pkg::LEN_W-1:0]  block_length_i,
  input  logic [urb_pkg::ROOM_W-1:0] read_room_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 result_kind_o,
  output logic [7:0]                 data_out_o,
  output logic                       accepted_o,
  output logic [urb_pkg::COUNT_W-1:0] line_count_o,
  output logic                       last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic             cmd_valid, cmd_pop, res_valid;
  urb_pkg::cmd_t    cmd;
  urb_pkg::result_t res;
  logic [7:0]       term_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == urb_pkg::REG_LINE_TERM) ? {24'd0, term_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= urb_pkg::TERM_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == urb_pkg::REG_LINE_TERM)) begin
      term_q <= pwdata[7:0];
    end
  end

  urb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .opcode_i         (opcode_i),
    .data_in_i        (data_in_i),
    .first_of_block_i (first_of_block_i),
    .block_length_i   (block_length_i),
    .read_room_i      (read_room_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  urb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .line_term_i (term_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty         = !res_valid;
  assign result_kind_o = res.kind;
  assign data_out_o    = res.data;
  assign accepted_o    = res.accepted;
  assign line_count_o  = res.count;
  assign last_o        = res.last;

endmodule

### tb/tb_uart_tx_rx_ring_buffers.sv
// ----------------------------------------------------------------------------
// tb_uart_tx_rx_ring_buffers
// Self-checking bench for the UART transmit/receive ring buffers: a directed
// table, a receive-overflow fill, then random transmit blocks, line traffic
// and line reads, mostly under random idling, all checked against a cycle-free
// predictor of both rings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uart_tx_rx_ring_buffers;

  localparam int          NO_CHECK    = -1;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned FILL_BYTES  = urb_pkg::RECEIVE_DEPTH + 2;
  localparam int unsigned DIR_ROWS    = 27;

  typedef struct packed {
    logic [1:0]                 op;
    logic [7:0]                 data;
    logic                       first;
    logic [urb_pkg::LEN_W-1:0]  len;
    logic [urb_pkg::ROOM_W-1:0] room;
    logic                       typed;  // want holds a hand-written expectation
    urb_pkg::result_t           want;
  } uart_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [2:0] result_kind_o;
  logic [7:0] data_out_o;
  logic accepted_o;
  logic [urb_pkg::COUNT_W-1:0] line_count_o;
  logic last_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  uart_req_t cur = '0;
  uart_req_t request_q[$];
  urb_pkg::result_t pending_results[$];

  // predictor state
  logic [7:0] tx_ring[urb_pkg::SEND_DEPTH];
  logic [7:0] rx_ring[urb_pkg::RECEIVE_DEPTH];
  urb_pkg::tx_ptr_t tx_rd = '0, tx_wr = '0;
  urb_pkg::rx_ptr_t rx_rd = '0, rx_wr = '0;
  logic tx_armed = 1'b0;
  logic blk_open = 1'b0;
  logic [7:0] blk_left = '0;
  logic [7:0] line_term = urb_pkg::TERM_RESET;

  int unsigned errors = 0;
  int unsigned accepted_reqs = 0;
  int unsigned checked_results = 0;
  int unsigned stall_cycles = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit hold_go = 1'b0;
  bit calm = 1'b0;
  bit taken = 1'b0;
  int n0;

  always #5 clk_i = ~clk_i;

  uart_tx_rx_ring_buffers DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .opcode_i         (cur.op),
    .data_in_i        (cur.data),
    .first_of_block_i (cur.first),
    .block_length_i   (cur.len),
    .read_room_i      (cur.room),
    .empty            (empty),
    .pop              (pop),
    .result_kind_o    (result_kind_o),
    .data_out_o       (data_out_o),
    .accepted_o       (accepted_o),
    .line_count_o     (line_count_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic uart_req_t row(input logic [1:0] op, input logic [7:0] data,
                                    input logic first, input logic [7:0] len,
                                    input logic [6:0] room, input int want_kind = NO_CHECK,
                                    input logic want_acc = 1'b0);
    uart_req_t r;
    r = '0;
    r.op = op;
    r.data = data;
    r.first = first;
    r.len = len;
    r.room = room;
    if (want_kind != NO_CHECK) begin
      r.typed = 1'b1;
      r.want.kind = want_kind[2:0];
      r.want.accepted = want_acc;
      r.want.last = 1'b1;
    end
    return r;
  endfunction

  // Works out the results of one accepted request and advances the ring that it uses
  function automatic void predict_ring_results(input uart_req_t r);
    int unsigned room, lim, n;
    logic [7:0] b;
    bit stop;
    urb_pkg::result_t res;
    res = '0;
    res.last = 1'b1;
    case (r.op) inside
      urb_pkg::OP_SEND_BYTE, urb_pkg::OP_RX_BYTE: begin
        res.kind = urb_pkg::KIND_OUTCOME;
        if (r.op == urb_pkg::OP_RX_BYTE) begin
          if (urb_pkg::rx_ptr_t'(rx_wr - rx_rd) < urb_pkg::RECEIVE_DEPTH) begin
            rx_ring[rx_wr[urb_pkg::RECEIVE_IDX_W-1:0]] = r.data;
            rx_wr++;
            res.accepted = 1'b1;
          end
        end else if (r.first) begin
          blk_open = 1'b0;
          blk_left = '0;
          if (r.len == 0) begin
            tx_armed = 1'b1;
            res.accepted = 1'b1;
          end else if (urb_pkg::SEND_DEPTH - urb_pkg::tx_ptr_t'(tx_wr - tx_rd) >= r.len) begin
            tx_ring[tx_wr[urb_pkg::SEND_IDX_W-1:0]] = r.data;
            tx_wr++;
            res.accepted = 1'b1;
            blk_left = r.len - 8'd1;
            if (blk_left == 0) tx_armed = 1'b1;
            else blk_open = 1'b1;
          end
        end else if (blk_open) begin
          tx_ring[tx_wr[urb_pkg::SEND_IDX_W-1:0]] = r.data;
          tx_wr++;
          res.accepted = 1'b1;
          blk_left--;
          if (blk_left == 0) begin
            blk_open = 1'b0;
            tx_armed = 1'b1;
          end
        end
        pending_results.push_back(res);
      end
      urb_pkg::OP_TX_READY: begin
        if (tx_armed) begin
          if (tx_wr == tx_rd) begin
            tx_armed = 1'b0;
            res.kind = urb_pkg::KIND_DISARMED;
          end else begin
            res.kind = urb_pkg::KIND_TX_BYTE;
            res.data = tx_ring[tx_rd[urb_pkg::SEND_IDX_W-1:0]];
            tx_rd++;
          end
          pending_results.push_back(res);
        end
      end
      default: begin
        room = (r.room > urb_pkg::MAX_READ_ROOM) ? urb_pkg::MAX_READ_ROOM : r.room;
        if (room <= 1 || rx_wr == rx_rd) begin
          res.kind = urb_pkg::KIND_EMPTY_LINE;
          pending_results.push_back(res);
        end else begin
          lim = room - 1;
          n = 0;
          do begin
            b = rx_ring[rx_rd[urb_pkg::RECEIVE_IDX_W-1:0]];
            rx_rd++;
            n++;
            stop = (b == line_term) || (rx_wr == rx_rd) || (n >= lim);
            res.kind = urb_pkg::KIND_LINE_BYTE;
            res.data = b;
            res.count = stop ? urb_pkg::COUNT_W'(n) : '0;
            res.last = stop;
            pending_results.push_back(res);
          end while (!stop);
        end
      end
    endcase
  endfunction

  // Result check first, then prediction of the request taken at this edge
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, kind", result_kind_o, 0);
      end else begin
        if (result_kind_o !== pending_results[0].kind)
          report_mismatch("result_kind", result_kind_o, pending_results[0].kind);
        if (data_out_o !== pending_results[0].data)
          report_mismatch("data_out", data_out_o, pending_results[0].data);
        if (accepted_o !== pending_results[0].accepted)
          report_mismatch("accepted", accepted_o, pending_results[0].accepted);
        if (line_count_o !== pending_results[0].count)
          report_mismatch("line_count", line_count_o, pending_results[0].count);
        if (last_o !== pending_results[0].last)
          report_mismatch("last", last_o, pending_results[0].last);
        void'(pending_results.pop_front());
        checked_results++;
      end
    end
    if (push && full) stall_cycles++;
    taken = push && !full;
    if (taken) begin
      n0 = pending_results.size();
      predict_ring_results(cur);
      if (cur.typed && pending_results.size() == n0 + 1) pending_results[n0] = cur.want;
      accepted_reqs++;
    end
  end

  // request side
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || taken) begin
      if (request_q.size() > 0 && (calm || $urandom_range(0, 99) >= 31)) begin
        cur = request_q.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && (calm || $urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (request_q.size() != 0 || push || pending_results.size() != 0) @(posedge clk_i);
    // a ready while disarmed gives nothing back, so let the pipe drain
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_terminator(input logic [7:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {urb_pkg::REG_LINE_TERM, 2'b00};
    pwdata <= {24'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== v) report_mismatch("line_terminator readback", prdata[7:0], v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    line_term = v;
  endtask

  // Mostly well-formed sequences with random content, some broken blocks and noise
  task automatic queue_traffic(input int unsigned n_items);
    int unsigned added, pick, len, cnt, i;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 255);
        // long blocks are mostly cut short and later abandoned
        cnt = (len > 6) ? $urandom_range(0, 8) : ((len > 0) ? len - 1 : 0);
        request_q.push_back(row(urb_pkg::OP_SEND_BYTE, 8'($urandom), 1'b1, 8'(len),
                                7'($urandom)));
        for (i = 0; i < cnt; i++)
          request_q.push_back(row(urb_pkg::OP_SEND_BYTE, 8'($urandom), 1'b0, 8'($urandom),
                                  7'($urandom)));
        added += cnt + 1;
        if ($urandom_range(0, 9) == 0) begin
          request_q.push_back(row(urb_pkg::OP_SEND_BYTE, 8'($urandom), 1'b0, 8'($urandom),
                                  7'($urandom)));
          added++;
        end
      end else if (pick < 50) begin
        cnt = $urandom_range(1, 6);
        for (i = 0; i < cnt; i++)
          request_q.push_back(row(urb_pkg::OP_TX_READY, 8'($urandom), 1'($urandom),
                                  8'($urandom), 7'($urandom)));
        added += cnt;
      end else if (pick < 80) begin
        cnt = $urandom_range(0, 8);
        for (i = 0; i < cnt; i++)
          request_q.push_back(row(urb_pkg::OP_RX_BYTE, 8'($urandom), 1'($urandom),
                                  8'($urandom), 7'($urandom)));
        added += cnt;
        if ($urandom_range(0, 9) < 7) begin
          request_q.push_back(row(urb_pkg::OP_RX_BYTE, line_term, 1'($urandom), 8'($urandom),
                                  7'($urandom)));
          added++;
        end
      end else begin
        pick = $urandom_range(0, 9);
        len = (pick < 6) ? $urandom_range(2, 64) :
              (pick < 8) ? $urandom_range(0, 1) : $urandom_range(65, 127);
        request_q.push_back(row(urb_pkg::OP_LINE_READ, 8'($urandom), 1'($urandom),
                                8'($urandom), 7'(len)));
        added++;
      end
    end
  endtask

  initial begin
    logic [7:0] b;
    int unsigned i;
    uart_req_t directed [DIR_ROWS];
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_terminator(urb_pkg::TERM_RESET);
    // directed table: op, data, first, len, room, typed kind, typed accepted
    directed = '{
      row(urb_pkg::OP_TX_READY,  8'h00, 1'b0, 8'd0,   7'd0),
      row(urb_pkg::OP_LINE_READ, 8'h00, 1'b0, 8'd0,   7'd64, urb_pkg::KIND_EMPTY_LINE),
      row(urb_pkg::OP_SEND_BYTE, 8'h77, 1'b1, 8'd0,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_TX_READY,  8'h00, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_DISARMED),
      row(urb_pkg::OP_SEND_BYTE, 8'h5A, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b0),
      row(urb_pkg::OP_SEND_BYTE, 8'hFF, 1'b1, 8'd3,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_SEND_BYTE, 8'h00, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_SEND_BYTE, 8'hA5, 1'b1, 8'd1,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_TX_READY,  8'h00, 1'b0, 8'd0,   7'd0),
      row(urb_pkg::OP_TX_READY,  8'h00, 1'b0, 8'd0,   7'd0),
      row(urb_pkg::OP_TX_READY,  8'h00, 1'b0, 8'd0,   7'd0),
      row(urb_pkg::OP_TX_READY,  8'h00, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_DISARMED),
      row(urb_pkg::OP_SEND_BYTE, 8'h01, 1'b1, 8'd255, 7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_SEND_BYTE, 8'h02, 1'b1, 8'd255, 7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_SEND_BYTE, 8'h03, 1'b1, 8'd255, 7'd0,  urb_pkg::KIND_OUTCOME, 1'b0),
      row(urb_pkg::OP_SEND_BYTE, 8'h04, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b0),
      row(urb_pkg::OP_SEND_BYTE, 8'h00, 1'b1, 8'd0,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_TX_READY,  8'h00, 1'b0, 8'd0,   7'd0),
      row(urb_pkg::OP_TX_READY,  8'h00, 1'b0, 8'd0,   7'd0),
      row(urb_pkg::OP_TX_READY,  8'h00, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_DISARMED),
      row(urb_pkg::OP_RX_BYTE,   8'h41, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_RX_BYTE,   8'h0A, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_RX_BYTE,   8'h42, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_OUTCOME, 1'b1),
      row(urb_pkg::OP_LINE_READ, 8'h00, 1'b0, 8'd0,   7'd127),
      row(urb_pkg::OP_LINE_READ, 8'h00, 1'b0, 8'd0,   7'd1,  urb_pkg::KIND_EMPTY_LINE),
      row(urb_pkg::OP_LINE_READ, 8'h00, 1'b0, 8'd0,   7'd0,  urb_pkg::KIND_EMPTY_LINE),
      row(urb_pkg::OP_LINE_READ, 8'h00, 1'b0, 8'd0,   7'd2)
    };
    foreach (directed[k]) request_q.push_back(directed[k]);
    wait_idle();

    // overflow the receive ring while results are held back, then drain it
    hold_go = 1'b1;
    for (i = 0; i < FILL_BYTES; i++) begin
      b = 8'($urandom);
      if (b == line_term) b = ~b;
      request_q.push_back(row(urb_pkg::OP_RX_BYTE, b, 1'($urandom), 8'($urandom),
                              7'($urandom)));
    end
    repeat (5) request_q.push_back(row(urb_pkg::OP_LINE_READ, 8'h00, 1'b0, 8'd0, 7'd64));
    wait_idle();

    set_terminator(8'($urandom));
    queue_traffic(22);
    wait_idle();
    set_terminator(8'h00);
    calm = 1'b1;
    queue_traffic(22);
    wait_idle();
    calm = 1'b0;
    set_terminator(8'hFF);
    queue_traffic(22);
    wait_idle();
    set_terminator(8'($urandom));
    queue_traffic(22);
    wait_idle();

    $display("Run covered %0d requests and %0d checked results; input stalled %0d cycles.",
             accepted_reqs, checked_results, stall_cycles);
    $display("Blocks admitted, rejected and abandoned; receive overflow; five terminators.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
